/* rtl/ptt_pkg.sv */
// package: field widths, op, kind and status codes of the periodic timer table
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

    localparam int OP_W     = 3;
    localparam int SLOT_W   = 3;
    localparam int PERIOD_W = 16;
    localparam int KIND_W   = 2;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;
    localparam int REP_W    = 8;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_op OP_ADD    = 3'd0;
    localparam t_op OP_DELETE = 3'd1;
    localparam t_op OP_START  = 3'd2;
    localparam t_op OP_STOP   = 3'd3;
    localparam t_op OP_RESET  = 3'd4;
    localparam t_op OP_TIMER  = 3'd5;

    localparam t_kind KIND_SINGLE = 2'd0;
    localparam t_kind KIND_REPEAT = 2'd1;
    localparam t_kind KIND_BUFFER = 2'd2;
    localparam t_kind KIND_ASYNC  = 2'd3;

    localparam t_status ST_ACK      = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_DISPATCH = 2'd2;
    localparam t_status ST_DONE     = 2'd3;

endpackage

`default_nettype wire

/* rtl/ptt_in_if.sv */
// interface: request channel of the periodic timer table
`timescale 1ns / 1ps
`default_nettype none

interface ptt_in_if;
    import ptt_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period;
    logic [KIND_W-1:0]   kind;
    logic                start_running;
    logic                process_now;
    logic [TIME_W-1:0]   time_now;

    modport source (
        output valid, op, slot, period, kind, start_running, process_now, time_now,
        input  ready
    );

    modport sink (
        input  valid, op, slot, period, kind, start_running, process_now, time_now,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/ptt_out_if.sv */
// interface: result channel of the periodic timer table
`timescale 1ns / 1ps
`default_nettype none

interface ptt_out_if;
    import ptt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   result_slot;
    logic [REP_W-1:0]    repeat_count;
    logic                slot_is_running;
    logic [TIME_W-1:0]   dispatch_time;
    logic                last;

    modport source (
        output valid, status, result_slot, repeat_count, slot_is_running,
               dispatch_time, last,
        input  ready
    );

    modport sink (
        input  valid, status, result_slot, repeat_count, slot_is_running,
               dispatch_time, last,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/periodic_task_timer_table_unit.sv */
// top level: periodic timer slot table with a one-slot-per-cycle scan sequencer
// add searches the slots in order for a free one, one slot per cycle
// delete, start, stop, reset and unknown ops load their result in the accept cycle
// enabled tick and process: after a read prime, one slot read and update per cycle
// through the shared slot memory port unless a dispatch waits, then a final result
// i_rst_n synchronous: all slots unused and stopped, scheduler disabled
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_timer_table_unit #(
    parameter int SLOTS        = 8,
    parameter int PERIOD_BITS  = 16,
    parameter int PENDING_BITS = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata,
    ptt_in_if.sink     i_in,
    ptt_out_if.source  o_out
);
    import ptt_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = PERIOD_BITS + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD   = 3'd1;
    localparam logic [2:0] S_PRIME = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    logic [2:0]              r_state, n_state;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic                    r_sched_en;
    logic                    r_mode_proc, n_mode_proc;
    logic [TIME_W-1:0]       r_time;
    logic [PERIOD_BITS-1:0]  r_add_period;
    t_kind                   r_add_kind;
    logic                    r_add_run;
    logic [SLOTS-1:0]        r_used, n_used;
    logic [SLOTS-1:0]        r_running, n_running;

    // slot memories
    t_kind                   m_kind   [SLOTS];
    logic [PERIOD_BITS-1:0]  m_period [SLOTS];
    logic [CNT_W-1:0]        m_count  [SLOTS];
    logic [PENDING_BITS-1:0] m_pend   [SLOTS];
    t_kind                   r_rd_kind;
    logic [PERIOD_BITS-1:0]  r_rd_period;
    logic [CNT_W-1:0]        r_rd_count;
    logic [PENDING_BITS-1:0] r_rd_pend;

    logic                    w_rd_en;
    logic [IDX_W-1:0]        w_rd_addr;
    logic                    w_we_def;
    logic                    w_we_cp;
    logic [IDX_W-1:0]        w_waddr;
    logic [CNT_W-1:0]        w_wcount;
    logic [PENDING_BITS-1:0] w_wpend;

    // output register
    logic                    r_out_valid;
    t_status                 r_out_status, n_out_status;
    logic [SLOT_W-1:0]       r_out_slot, n_out_slot;
    logic [REP_W-1:0]        r_out_rep, n_out_rep;
    logic                    r_out_run, n_out_run;
    logic [TIME_W-1:0]       r_out_time, n_out_time;
    logic                    r_out_last, n_out_last;
    logic                    w_out_load;
    logic                    w_out_free;

    logic                    w_accept;
    logic [IDX_W-1:0]        w_slot_idx;
    logic                    w_in_range;

    // slot update unit
    logic                    w_live;
    logic [CNT_W-1:0]        w_cnt_inc;
    logic [CNT_W-1:0]        w_per_ext;
    logic [CNT_W-1:0]        w_new_count;
    logic [PENDING_BITS-1:0] w_new_pend;
    logic [REP_W-1:0]        w_rep;
    logic                    w_new_run;
    logic                    w_fire;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_slot_idx = IDX_W'(i_in.slot);
    assign w_in_range = 32'(i_in.slot) < SLOTS;

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out_status;
    assign o_out.result_slot     = r_out_slot;
    assign o_out.repeat_count    = r_out_rep;
    assign o_out.slot_is_running = r_out_run;
    assign o_out.dispatch_time   = r_out_time;
    assign o_out.last            = r_out_last;

    assign w_live    = r_used[r_idx] && r_running[r_idx];
    assign w_cnt_inc = r_rd_count + CNT_W'(1);
    assign w_per_ext = CNT_W'(r_rd_period);
    assign w_fire    = (w_rep != '0);

    always_comb begin
        w_new_count = r_rd_count;
        w_new_pend  = r_rd_pend;
        w_rep       = '0;
        w_new_run   = r_running[r_idx];
        if (w_live) begin
            if (!r_mode_proc) begin
                if (r_rd_kind != KIND_ASYNC) begin
                    w_new_count = w_cnt_inc;
                    if (w_cnt_inc >= w_per_ext) begin
                        w_new_count = '0;
                        if (r_rd_kind == KIND_BUFFER) begin
                            if (r_rd_pend != {PENDING_BITS{1'b1}}) begin
                                w_new_pend = r_rd_pend + PENDING_BITS'(1);
                            end
                        end else begin
                            w_new_pend = PENDING_BITS'(1);
                        end
                    end
                end
            end else begin
                case (r_rd_kind)
                    KIND_SINGLE, KIND_REPEAT: begin
                        if (r_rd_pend != '0) begin
                            w_rep      = REP_W'(1);
                            w_new_pend = '0;
                            if (r_rd_kind == KIND_SINGLE) begin
                                w_new_run = 1'b0;
                            end
                        end
                    end
                    KIND_BUFFER: begin
                        if (r_rd_pend > PENDING_BITS'(255)) begin
                            w_rep = REP_W'(255);
                        end else begin
                            w_rep = REP_W'(r_rd_pend);
                        end
                        w_new_pend = r_rd_pend - PENDING_BITS'(w_rep);
                    end
                    default: begin
                        w_new_count = w_cnt_inc;
                        if (w_cnt_inc > w_per_ext) begin
                            w_new_count = '0;
                            w_rep       = REP_W'(1);
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_mode_proc  = r_mode_proc;
        n_used       = r_used;
        n_running    = r_running;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_idx;
        w_we_def     = 1'b0;
        w_we_cp      = 1'b0;
        w_waddr      = r_idx;
        w_wcount     = '0;
        w_wpend      = '0;
        w_out_load   = 1'b0;
        n_out_status = ST_ACK;
        n_out_slot   = '0;
        n_out_rep    = '0;
        n_out_run    = 1'b0;
        n_out_time   = '0;
        n_out_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in.op)
                        OP_ADD: begin
                            n_idx   = '0;
                            n_state = S_ADD;
                        end
                        OP_DELETE, OP_START, OP_STOP, OP_RESET: begin
                            w_out_load = 1'b1;
                            n_out_slot = i_in.slot;
                            if (w_in_range) begin
                                n_out_run = r_running[w_slot_idx];
                                case (i_in.op)
                                    OP_DELETE: n_used[w_slot_idx] = 1'b0;
                                    OP_START: begin
                                        n_running[w_slot_idx] = 1'b1;
                                        n_out_run             = 1'b1;
                                    end
                                    OP_STOP: begin
                                        n_running[w_slot_idx] = 1'b0;
                                        n_out_run             = 1'b0;
                                    end
                                    default: begin
                                        n_running[w_slot_idx] = 1'b1;
                                        n_out_run             = 1'b1;
                                        w_we_cp               = 1'b1;
                                        w_waddr               = w_slot_idx;
                                    end
                                endcase
                            end
                        end
                        OP_TIMER: begin
                            if (r_sched_en) begin
                                n_mode_proc = i_in.process_now;
                                n_idx       = '0;
                                n_state     = S_PRIME;
                            end else begin
                                w_out_load = 1'b1;
                                if (i_in.process_now) begin
                                    n_out_status = ST_DONE;
                                end
                            end
                        end
                        default: begin
                            w_out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_ADD: begin
                if (!r_used[r_idx]) begin
                    if (w_out_free) begin
                        w_we_def          = 1'b1;
                        w_we_cp           = 1'b1;
                        n_used[r_idx]     = 1'b1;
                        n_running[r_idx]  = r_add_run;
                        w_out_load        = 1'b1;
                        n_out_slot        = SLOT_W'(r_idx);
                        n_out_run         = r_add_run;
                        n_state           = S_IDLE;
                    end
                end else if (r_idx == LAST_IDX) begin
                    if (w_out_free) begin
                        w_out_load   = 1'b1;
                        n_out_status = ST_FULL;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_PRIME: begin
                w_rd_en = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!w_fire || w_out_free) begin
                    w_we_cp          = w_live;
                    w_wcount         = w_new_count;
                    w_wpend          = w_new_pend;
                    n_running[r_idx] = w_new_run;
                    if (w_fire) begin
                        w_out_load   = 1'b1;
                        n_out_status = ST_DISPATCH;
                        n_out_slot   = SLOT_W'(r_idx);
                        n_out_rep    = w_rep;
                        n_out_run    = w_new_run;
                        n_out_time   = r_time;
                        n_out_last   = 1'b0;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx     = r_idx + IDX_W'(1);
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_idx + IDX_W'(1);
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_out_load   = 1'b1;
                    n_out_status = r_mode_proc ? ST_DONE : ST_ACK;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_sched_en  <= 1'b0;
            r_mode_proc <= 1'b0;
            r_used      <= '0;
            r_running   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_mode_proc <= n_mode_proc;
            r_used      <= n_used;
            r_running   <= n_running;
            if (i_cfg_we) begin
                r_sched_en <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_time       <= i_in.time_now;
            r_add_period <= PERIOD_BITS'(i_in.period);
            r_add_kind   <= i_in.kind;
            r_add_run    <= i_in.start_running;
        end
        if (w_out_load) begin
            r_out_status <= n_out_status;
            r_out_slot   <= n_out_slot;
            r_out_rep    <= n_out_rep;
            r_out_run    <= n_out_run;
            r_out_time   <= n_out_time;
            r_out_last   <= n_out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_def) begin
            m_kind[w_waddr]   <= r_add_kind;
            m_period[w_waddr] <= r_add_period;
        end
        if (w_we_cp) begin
            m_count[w_waddr] <= w_wcount;
            m_pend[w_waddr]  <= w_wpend;
        end
        if (w_rd_en) begin
            r_rd_kind   <= m_kind[w_rd_addr];
            r_rd_period <= m_period[w_rd_addr];
            r_rd_count  <= m_count[w_rd_addr];
            r_rd_pend   <= m_pend[w_rd_addr];
        end
    end

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("slot index beyond table");

    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_out_valid) |-> r_out_last)
        else $error("non-final result left pending while idle");

    a_dispatch_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_DISPATCH)
            |-> (r_state == S_EVAL || r_state == S_DONE))
        else $error("dispatch result outside a process scan");

    a_start_sets_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.op == OP_START && w_in_range)
            |=> r_running[$past(w_slot_idx)])
        else $error("start did not set run flag");
`endif

endmodule

`default_nettype wire

/* tb/periodic_task_timer_table_unit_tb.sv */
// testbench: periodic timer table against a cycle-free predictor, random gaps on both channels
`timescale 1ns / 1ps

module periodic_task_timer_table_unit_tb;
    import ptt_pkg::*;

    localparam int TBL_SLOTS      = 8;
    localparam int SETTLE_CYCLES  = TBL_SLOTS + 5;
    localparam int WATCHDOG_LIMIT = 1500;
    localparam int REPORT_LIMIT   = 10;
    localparam int BURST_TICKS    = 30;

    localparam t_op OP_SPARE_A = 3'd6;
    localparam t_op OP_SPARE_B = 3'd7;

    typedef struct packed {
        t_op                 op;
        logic [SLOT_W-1:0]   slot;
        logic [PERIOD_W-1:0] period;
        t_kind               kind;
        logic                start_running;
        logic                process_now;
        logic [TIME_W-1:0]   time_now;
    } t_request;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [REP_W-1:0]    runs;
        logic                running;
        logic [TIME_W-1:0]   stamp;
        logic                last;
    } t_response;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;

    logic                req_valid = 1'b0;
    t_op                 req_op = '0;
    logic [SLOT_W-1:0]   req_slot = '0;
    logic [PERIOD_W-1:0] req_period = '0;
    t_kind               req_kind = '0;
    logic                req_start = 1'b0;
    logic                req_proc = 1'b0;
    logic [TIME_W-1:0]   req_time = '0;
    logic                rsp_ready = 1'b0;

    ptt_in_if  req_if ();
    ptt_out_if rsp_if ();

    assign req_if.valid         = req_valid;
    assign req_if.op            = req_op;
    assign req_if.slot          = req_slot;
    assign req_if.period        = req_period;
    assign req_if.kind          = req_kind;
    assign req_if.start_running = req_start;
    assign req_if.process_now   = req_proc;
    assign req_if.time_now      = req_time;
    assign rsp_if.ready         = rsp_ready;

    periodic_task_timer_table_unit #(
        .SLOTS        (TBL_SLOTS),
        .PERIOD_BITS  (PERIOD_W),
        .PENDING_BITS (REP_W)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (req_if),
        .o_out       (rsp_if)
    );

    always #10 clk = ~clk;

    // mirror of the slot table
    bit                  sched_enabled;
    bit                  tbl_used    [TBL_SLOTS];
    t_kind               tbl_kind    [TBL_SLOTS];
    bit                  tbl_running [TBL_SLOTS];
    logic [PERIOD_W-1:0] tbl_period  [TBL_SLOTS];
    logic [PERIOD_W:0]   tbl_count   [TBL_SLOTS];
    logic [REP_W-1:0]    tbl_pending [TBL_SLOTS];

    t_request  request_queue[$];
    t_response awaited_responses[$];

    t_request  held_req;
    bit        holding;
    int        send_gap;
    int        stall_left;
    bit        steady_mode;
    int        mismatches;
    int        quiet_cycles;
    t_response want_rsp;
    t_response got_rsp;

    function automatic t_response make_response(t_status st, logic [SLOT_W-1:0] sl,
                                                logic [REP_W-1:0] runs, logic run,
                                                logic [TIME_W-1:0] stamp, logic last);
        t_response r;
        r.status  = st;
        r.slot    = sl;
        r.runs    = runs;
        r.running = run;
        r.stamp   = stamp;
        r.last    = last;
        return r;
    endfunction

    task automatic advance_ticks();
        for (int i = 0; i < TBL_SLOTS; i++) begin
            if (tbl_used[i] && tbl_running[i] && tbl_kind[i] != KIND_ASYNC) begin
                tbl_count[i] = tbl_count[i] + 1'b1;
                if (tbl_count[i] >= {1'b0, tbl_period[i]}) begin
                    tbl_count[i] = '0;
                    if (tbl_kind[i] == KIND_BUFFER) begin
                        if (tbl_pending[i] != '1)
                            tbl_pending[i] = tbl_pending[i] + 1'b1;
                    end else begin
                        tbl_pending[i] = REP_W'(1);
                    end
                end
            end
        end
    endtask

    task automatic scan_due_slots(input logic [TIME_W-1:0] stamp);
        logic [REP_W-1:0] runs;
        for (int i = 0; i < TBL_SLOTS; i++) begin
            runs = '0;
            if (tbl_used[i] && tbl_running[i]) begin
                case (tbl_kind[i])
                    KIND_SINGLE, KIND_REPEAT: begin
                        if (tbl_pending[i] != 0) begin
                            runs = REP_W'(1);
                            tbl_pending[i] = '0;
                            if (tbl_kind[i] == KIND_SINGLE)
                                tbl_running[i] = 1'b0;
                        end
                    end
                    KIND_BUFFER: begin
                        runs = tbl_pending[i];
                        tbl_pending[i] = tbl_pending[i] - runs;
                    end
                    default: begin
                        tbl_count[i] = tbl_count[i] + 1'b1;
                        if (tbl_count[i] > {1'b0, tbl_period[i]}) begin
                            tbl_count[i] = '0;
                            runs = REP_W'(1);
                        end
                    end
                endcase
                if (runs != 0)
                    awaited_responses.push_back(make_response(ST_DISPATCH, SLOT_W'(i), runs,
                                                              tbl_running[i], stamp, 1'b0));
            end
        end
        awaited_responses.push_back(make_response(ST_DONE, '0, '0, 1'b0, '0, 1'b1));
    endtask

    task automatic apply_timer_request(input t_request rq);
        int free_slot;
        free_slot = -1;
        case (rq.op)
            OP_ADD: begin
                for (int i = TBL_SLOTS - 1; i >= 0; i--)
                    if (!tbl_used[i])
                        free_slot = i;
                if (free_slot < 0) begin
                    awaited_responses.push_back(make_response(ST_FULL, '0, '0, 1'b0, '0, 1'b1));
                end else begin
                    tbl_used[free_slot]    = 1'b1;
                    tbl_kind[free_slot]    = rq.kind;
                    tbl_running[free_slot] = rq.start_running;
                    tbl_period[free_slot]  = rq.period;
                    tbl_count[free_slot]   = '0;
                    tbl_pending[free_slot] = '0;
                    awaited_responses.push_back(make_response(ST_ACK, SLOT_W'(free_slot), '0,
                                                              rq.start_running, '0, 1'b1));
                end
            end
            OP_DELETE, OP_START, OP_STOP, OP_RESET: begin
                case (rq.op)
                    OP_DELETE: tbl_used[rq.slot] = 1'b0;
                    OP_START:  tbl_running[rq.slot] = 1'b1;
                    OP_STOP:   tbl_running[rq.slot] = 1'b0;
                    default: begin
                        tbl_count[rq.slot]   = '0;
                        tbl_pending[rq.slot] = '0;
                        tbl_running[rq.slot] = 1'b1;
                    end
                endcase
                awaited_responses.push_back(make_response(ST_ACK, rq.slot, '0,
                                                          tbl_running[rq.slot], '0, 1'b1));
            end
            OP_TIMER: begin
                if (rq.process_now && sched_enabled) begin
                    scan_due_slots(rq.time_now);
                end else if (rq.process_now) begin
                    awaited_responses.push_back(make_response(ST_DONE, '0, '0, 1'b0, '0, 1'b1));
                end else begin
                    if (sched_enabled)
                        advance_ticks();
                    awaited_responses.push_back(make_response(ST_ACK, '0, '0, 1'b0, '0, 1'b1));
                end
            end
            default: begin
                awaited_responses.push_back(make_response(ST_ACK, '0, '0, 1'b0, '0, 1'b1));
            end
        endcase
    endtask

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_mode || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_request random_request();
        t_request rq;
        int pick;
        int span;
        pick = $urandom_range(0, 99);
        span = $urandom_range(0, 9);
        rq.slot          = SLOT_W'($urandom_range(0, TBL_SLOTS - 1));
        rq.kind          = t_kind'($urandom_range(0, 3));
        rq.start_running = ($urandom_range(0, 3) != 0);
        rq.time_now      = $urandom();
        if (span < 6)
            rq.period = PERIOD_W'($urandom_range(0, 4));
        else if (span < 8)
            rq.period = PERIOD_W'($urandom_range(5, 20));
        else
            rq.period = PERIOD_W'($urandom_range(0, 65535));
        rq.process_now = (pick >= 75);
        if (pick < 20)
            rq.op = OP_ADD;
        else if (pick < 28)
            rq.op = OP_DELETE;
        else if (pick < 36)
            rq.op = OP_START;
        else if (pick < 43)
            rq.op = OP_STOP;
        else if (pick < 49)
            rq.op = OP_RESET;
        else if (pick < 92)
            rq.op = OP_TIMER;
        else
            rq.op = ($urandom_range(0, 1) != 0) ? OP_SPARE_B : OP_SPARE_A;
        return rq;
    endfunction

    task automatic queue_request(input t_op op, input int slot, input int period,
                                 input t_kind kind, input bit start, input bit proc,
                                 input logic [TIME_W-1:0] stamp);
        t_request rq;
        rq.op            = op;
        rq.slot          = SLOT_W'(slot);
        rq.period        = PERIOD_W'(period);
        rq.kind          = kind;
        rq.start_running = start;
        rq.process_now   = proc;
        rq.time_now      = stamp;
        request_queue.push_back(rq);
    endtask

    task automatic drain_table();
        do
            @(negedge clk);
        while (request_queue.size() != 0 || holding || awaited_responses.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_scheduler_enable(input bit en);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= en;
        sched_enabled = en;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_phase(input bit en, input bit steady, input int count);
        drain_table();
        write_scheduler_enable(en);
        steady_mode = steady;
        repeat (count) request_queue.push_back(random_request());
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            holding  = 1'b0;
            send_gap = 0;
        end else begin
            if (holding && req_if.ready) begin
                apply_timer_request(held_req);
                holding  = 1'b0;
                send_gap = draw_gap();
            end
            if (!holding) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (request_queue.size() != 0) begin
                    held_req   = request_queue.pop_front();
                    holding    = 1'b1;
                    req_op     <= held_req.op;
                    req_slot   <= held_req.slot;
                    req_period <= held_req.period;
                    req_kind   <= held_req.kind;
                    req_start  <= held_req.start_running;
                    req_proc   <= held_req.process_now;
                    req_time   <= held_req.time_now;
                end
            end
        end
        req_valid <= holding;
    end

    // response monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ready  <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_if.valid && rsp_ready) begin
                got_rsp = make_response(rsp_if.status, rsp_if.result_slot, rsp_if.repeat_count,
                                        rsp_if.slot_is_running, rsp_if.dispatch_time,
                                        rsp_if.last);
                if (awaited_responses.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t unexpected transaction: status=%0d slot=%0d rep=%0d run=%0b time=%h last=%0b",
                                 $time, got_rsp.status, got_rsp.slot, got_rsp.runs,
                                 got_rsp.running, got_rsp.stamp, got_rsp.last);
                end else begin
                    want_rsp = awaited_responses.pop_front();
                    if (got_rsp.status != want_rsp.status || got_rsp.slot != want_rsp.slot ||
                        got_rsp.runs != want_rsp.runs || got_rsp.running != want_rsp.running ||
                        got_rsp.stamp != want_rsp.stamp || got_rsp.last != want_rsp.last) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t mismatch: expected status=%0d slot=%0d rep=%0d run=%0b time=%h last=%0b",
                                     $time, want_rsp.status, want_rsp.slot, want_rsp.runs,
                                     want_rsp.running, want_rsp.stamp, want_rsp.last);
                            $display("%0t          actual   status=%0d slot=%0d rep=%0d run=%0b time=%h last=%0b",
                                     $time, got_rsp.status, got_rsp.slot, got_rsp.runs,
                                     got_rsp.running, got_rsp.stamp, got_rsp.last);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready  <= 1'b1;
                stall_left = draw_gap();
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_we || (req_if.valid && req_if.ready) ||
            (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        write_scheduler_enable(1'b0);

        // scheduler off: timer items do nothing, fill the table
        queue_request(OP_TIMER, 0, 0, KIND_SINGLE, 0, 1, 32'h1234_5678);
        queue_request(OP_TIMER, 0, 0, KIND_SINGLE, 0, 0, 32'h0);
        queue_request(OP_ADD, 0, 0, KIND_SINGLE, 1, 0, 32'h0);
        queue_request(OP_ADD, 7, 65535, KIND_REPEAT, 0, 1, 32'hFFFF_FFFF);
        queue_request(OP_ADD, 0, 1, KIND_BUFFER, 1, 0, 32'h0);
        queue_request(OP_ADD, 0, 0, KIND_ASYNC, 1, 0, 32'h0);
        queue_request(OP_ADD, 0, 2, KIND_REPEAT, 1, 0, 32'h0);
        queue_request(OP_ADD, 0, 'hAAAA, KIND_SINGLE, 1, 0, 32'h0);
        queue_request(OP_ADD, 0, 3, KIND_BUFFER, 0, 0, 32'h0);
        queue_request(OP_ADD, 0, 5, KIND_ASYNC, 1, 0, 32'h0);
        queue_request(OP_ADD, 0, 4, KIND_REPEAT, 1, 0, 32'h0);
        queue_request(OP_SPARE_A, 5, 'h5555, KIND_ASYNC, 1, 1, 32'hA5A5_A5A5);
        queue_request(OP_SPARE_B, 7, 65535, KIND_BUFFER, 1, 0, 32'hFFFF_FFFF);
        drain_table();

        write_scheduler_enable(1'b1);
        queue_request(OP_TIMER, 0, 0, KIND_SINGLE, 0, 0, 32'h0);
        queue_request(OP_TIMER, 0, 0, KIND_SINGLE, 0, 0, 32'h0);
        queue_request(OP_TIMER, 0, 0, KIND_SINGLE, 0, 1, 32'hFFFF_FFFF);
        queue_request(OP_TIMER, 0, 0, KIND_SINGLE, 0, 1, 32'h0);
        queue_request(OP_DELETE, 3, 0, KIND_SINGLE, 0, 0, 32'h0);
        queue_request(OP_TIMER, 0, 0, KIND_SINGLE, 0, 1, 32'h0000_0001);
        queue_request(OP_START, 3, 0, KIND_SINGLE, 0, 0, 32'h0);
        queue_request(OP_STOP, 1, 0, KIND_SINGLE, 0, 0, 32'h0);
        queue_request(OP_RESET, 6, 0, KIND_SINGLE, 0, 0, 32'h0);
        queue_request(OP_ADD, 0, 0, KIND_ASYNC, 0, 0, 32'h0);
        queue_request(OP_TIMER, 0, 0, KIND_SINGLE, 0, 0, 32'h0);
        queue_request(OP_TIMER, 0, 0, KIND_SINGLE, 0, 1, 32'h8000_0000);

        // buffered backlog
        queue_request(OP_DELETE, 6, 0, KIND_SINGLE, 0, 0, 32'h0);
        queue_request(OP_ADD, 0, 0, KIND_BUFFER, 1, 0, 32'h0);
        repeat (BURST_TICKS) queue_request(OP_TIMER, 0, 0, KIND_SINGLE, 0, 0, 32'h0);
        queue_request(OP_TIMER, 0, 0, KIND_SINGLE, 0, 1, 32'h7FFF_FFFF);
        queue_request(OP_TIMER, 0, 0, KIND_SINGLE, 0, 1, 32'h0000_FFFF);

        random_phase(1'b1, 1'b0, 50);
        random_phase(1'b0, 1'b0, 15);
        random_phase(1'b1, 1'b1, 30);
        random_phase(1'b1, 1'b0, 50);
        drain_table();

        if (mismatches == 0 && awaited_responses.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
